FILE: design/evip_pkg.sv
// Package: word types, phase encoding and constants for the Ethernet/VLAN/IPv4 header parser.
package evip_pkg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] ip_version;
        logic       options_present;
        logic [5:0] dscp_value;
    } result_word_t;

    typedef enum logic [6:0] {
        PH_MAC     = 7'b0000001,
        PH_TYPE_HI = 7'b0000010,
        PH_TYPE_LO = 7'b0000100,
        PH_TAG_TCI = 7'b0001000,
        PH_IP_HDR  = 7'b0010000,
        PH_IP_DONE = 7'b0100000,
        PH_NOT_IP  = 7'b1000000
    } phase_t;

    localparam logic [1:0] STATUS_NOT_IP    = 2'd0;
    localparam logic [1:0] STATUS_IPV4      = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] TYPE_VLAN_AD = 16'h88A8;

    localparam logic [4:0] MAC_BYTES  = 5'd12;
    localparam logic [4:0] TCI_BYTES  = 5'd2;
    localparam logic [4:0] IP_HDR_MIN = 5'd20;

endpackage

FILE: design/ethernet_vlan_ipv4_header_parser.sv
// Top level: byte-stream Ethernet II parser with stacked VLAN tags and IPv4 header fields.
// Throughput: one frame word per cycle, unless a waiting result holds back a last word.
// A result word is valid once the last word of a frame has passed the input register
//   and then been loaded into the result register.
// A waiting result holds back only the last word of the next frame; other words advance.
// Reset: asynchronous, active low; clears all control state and starts in the MAC skip phase.
module ethernet_vlan_ipv4_header_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  evip_pkg::frame_word_t  frame_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output evip_pkg::result_word_t result_word
);
    import evip_pkg::*;

    logic         stage_valid_reg;
    logic         stage_valid_next;
    frame_word_t  stage_word_reg;
    logic         result_valid_reg;
    logic         result_valid_next;
    result_word_t result_word_reg;

    phase_t       phase_reg;
    phase_t       phase_next;
    logic [4:0]   count_reg;
    logic [4:0]   count_next;
    logic [7:0]   type_high_reg;
    logic [7:0]   type_high_next;
    logic [3:0]   version_reg;
    logic [3:0]   version_next;
    logic         options_reg;
    logic         options_next;
    logic [5:0]   dscp_reg;
    logic [5:0]   dscp_next;

    logic         out_free;
    logic         pipe_go;
    logic         out_load;
    logic [4:0]   count_inc;
    logic [15:0]  etype;
    logic [7:0]   b;
    logic [5:0]   ihl_bytes;
    result_word_t result_calc;

    assign b         = stage_word_reg.frame_byte;
    assign out_free  = !result_valid_reg || !result_stall;
    assign pipe_go   = stage_valid_reg && (!stage_word_reg.frame_last || out_free);
    assign out_load  = pipe_go && stage_word_reg.frame_last;
    assign count_inc = count_reg + 5'd1;
    assign etype     = {type_high_reg, b};
    assign ihl_bytes = {b[3:0], 2'b00};

    assign frame_stall  = stage_valid_reg && !pipe_go;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        type_high_next = type_high_reg;
        version_next   = version_reg;
        options_next   = options_reg;
        dscp_next      = dscp_reg;
        case (phase_reg)
            PH_MAC:
            begin
                count_next = count_inc;
                if (count_inc >= MAC_BYTES)
                begin
                    phase_next = PH_TYPE_HI;
                    count_next = '0;
                end
            end
            PH_TYPE_HI:
            begin
                type_high_next = b;
                phase_next     = PH_TYPE_LO;
            end
            PH_TYPE_LO:
            begin
                count_next = '0;
                if (etype == TYPE_VLAN_Q || etype == TYPE_VLAN_AD)
                    phase_next = PH_TAG_TCI;
                else if (etype == TYPE_IPV4)
                    phase_next = PH_IP_HDR;
                else
                    phase_next = PH_NOT_IP;
            end
            PH_TAG_TCI:
            begin
                count_next = count_inc;
                if (count_inc >= TCI_BYTES)
                begin
                    phase_next = PH_TYPE_HI;
                    count_next = '0;
                end
            end
            PH_IP_HDR:
            begin
                if (count_reg == 5'd0)
                begin
                    version_next = b[7:4];
                    options_next = ihl_bytes > {1'b0, IP_HDR_MIN};
                end
                else if (count_reg == 5'd1)
                begin
                    dscp_next = b[7:2];
                end
                count_next = count_inc;
                if (count_inc >= IP_HDR_MIN)
                    phase_next = PH_IP_DONE;
            end
            PH_IP_DONE:
            begin
            end
            PH_NOT_IP:
            begin
            end
            default:
            begin
                phase_next = PH_NOT_IP;
            end
        endcase
    end

    always_comb
    begin
        result_calc = '0;
        if (phase_next == PH_IP_DONE)
        begin
            result_calc.status          = STATUS_IPV4;
            result_calc.ip_version      = version_next;
            result_calc.options_present = options_next;
            result_calc.dscp_value      = dscp_next;
        end
        else if (phase_next == PH_NOT_IP)
        begin
            result_calc.status = STATUS_NOT_IP;
        end
        else
        begin
            result_calc.status = STATUS_TRUNCATED;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (!stage_valid_reg || pipe_go)
            stage_valid_next = frame_valid;
        result_valid_next = result_valid_reg;
        if (out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_MAC;
            count_reg        <= '0;
            type_high_reg    <= '0;
            version_reg      <= '0;
            options_reg      <= 1'b0;
            dscp_reg         <= '0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (pipe_go)
            begin
                if (stage_word_reg.frame_last)
                begin
                    phase_reg     <= PH_MAC;
                    count_reg     <= '0;
                    type_high_reg <= '0;
                    version_reg   <= '0;
                    options_reg   <= 1'b0;
                    dscp_reg      <= '0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    count_reg     <= count_next;
                    type_high_reg <= type_high_next;
                    version_reg   <= version_next;
                    options_reg   <= options_next;
                    dscp_reg      <= dscp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && !frame_stall)
            stage_word_reg <= frame_word;
        if (out_load)
            result_word_reg <= result_calc;
    end

    a_frame_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (phase_reg == PH_MAC && count_reg == 5'd0))
        else $error("parser not back in MAC phase after frame end");

    a_tag_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAG_TCI) |-> (count_reg < TCI_BYTES))
        else $error("tag byte count out of range");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_word_reg.status != 2'd3))
        else $error("illegal status code");

    a_fields_zero_unless_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_word_reg.status != STATUS_IPV4)
            |-> (result_word_reg.ip_version == 4'd0 && !result_word_reg.options_present
                 && result_word_reg.dscp_value == 6'd0))
        else $error("header fields set on non-IPv4 result");

    a_no_load_over_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule
